/* design/lmqt_pkg.sv */
// Shared widths, cell types and constants for the Lloyd-Max quantizer trainer.
`timescale 1ns / 1ps
package lmqt_pkg;
	localparam int SAMPLE_W = 16;
	localparam int FRAC_W = 8;
	localparam int LEVEL_W = 25;
	localparam int CENT_W = 24;
	localparam int SUM_W = 37;
	localparam int CNT_W = 21;
	localparam int CODE_W = 4;
	localparam int DIVD_W = SUM_W + FRAC_W;
	localparam int MAX_PASS_SAMPLES = 1048576;
	localparam int COUNT_CAP = (MAX_PASS_SAMPLES < 2097151) ? MAX_PASS_SAMPLES : 2097151;

	typedef struct packed {
		logic signed [LEVEL_W-1:0] level;
		logic signed [CENT_W-1:0] centroid;
		logic signed [SUM_W-1:0] sum;
		logic [CNT_W-1:0] count;
	} cell_t;

	typedef struct packed {
		logic shift;
		logic set_level;
	} cell_ctl_t;
endpackage

/* design/lmqt_cell.sv */
// One bin cell of the quantizer chain: level, centroid and accumulators.
`timescale 1ns / 1ps
module lmqt_cell (
	input logic clk,
	input logic arst_n,
	input lmqt_pkg::cell_ctl_t ctl,
	input logic is_top,
	input logic signed [lmqt_pkg::LEVEL_W-1:0] top_level,
	input lmqt_pkg::cell_t nxt,
	output lmqt_pkg::cell_t cur
);
	import lmqt_pkg::*;

	logic signed [LEVEL_W-1:0] level_q;
	logic signed [CENT_W-1:0] centroid_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] count_q;
	logic signed [CENT_W:0] mid_sum;

	assign mid_sum = {centroid_q[CENT_W-1], centroid_q} + {nxt.centroid[CENT_W-1], nxt.centroid};
	assign cur = '{level: level_q, centroid: centroid_q, sum: sum_q, count: count_q};

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			level_q <= nxt.level;
			centroid_q <= nxt.centroid;
		end else if (ctl.set_level) begin
			level_q <= is_top ? top_level : {mid_sum[CENT_W], mid_sum[CENT_W:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			count_q <= '0;
		end else if (ctl.shift) begin
			sum_q <= nxt.sum;
			count_q <= nxt.count;
		end
	end
endmodule

/* design/lmqt_div.sv */
// Restoring serial divider, one quotient bit per cycle, truncating signed quotient.
`timescale 1ns / 1ps
module lmqt_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [lmqt_pkg::DIVD_W-1:0] dividend,
	input logic [lmqt_pkg::CNT_W-1:0] divisor,
	output logic done,
	output logic signed [lmqt_pkg::CENT_W-1:0] quotient
);
	import lmqt_pkg::*;

	localparam int SW = $clog2(DIVD_W);

	logic busy_q;
	logic done_q;
	logic [SW-1:0] step_q;
	logic neg_q;
	logic [DIVD_W-1:0] quo_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] dsr_q;
	logic [CNT_W:0] shl;
	logic [CNT_W:0] diff;
	logic ge;

	assign shl = {rem_q, quo_q[DIVD_W-1]};
	assign diff = shl - {1'b0, dsr_q};
	assign ge = shl >= {1'b0, dsr_q};
	assign done = done_q;
	assign quotient = neg_q ? -$signed(quo_q[CENT_W-1:0]) : $signed(quo_q[CENT_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == SW'(DIVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DIVD_W-1];
			quo_q <= dividend[DIVD_W-1] ? DIVD_W'(-dividend) : DIVD_W'(dividend);
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[CNT_W-1:0] : shl[CNT_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], ge};
		end
	end
endmodule

/* design/lloyd_max_quantizer_trainer_unit.sv */
// Top level of the Lloyd-Max scalar quantizer trainer: cell chain, sequencer, divider.
//
// The block takes one transaction at a time. The last range-pass sample adds a setup (one
// multiply of the span by the reciprocal of BINS, then the quotient and remainder, then
// one rotation of the cell chain that writes uniform levels). For a training sample the
// cell chain rotates once past a single comparator to count levels below the sample, then
// once more to read the chosen centroid and update that bin's sum and count; the result
// then waits while the result register is stalled. The last training sample adds one
// serial divide per non-empty bin, skips each empty bin and then writes the new levels.
`timescale 1ns / 1ps
module lloyd_max_quantizer_trainer_unit #(
	parameter int BINS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input logic kind,
	input logic signed [lmqt_pkg::SAMPLE_W-1:0] sample,
	input logic last_of_pass,
	output logic result_valid,
	input logic result_stall,
	output logic [lmqt_pkg::CODE_W-1:0] bin_code,
	output logic signed [lmqt_pkg::CENT_W-1:0] recon_value
);
	import lmqt_pkg::*;

	localparam int BW = $clog2(BINS);
	localparam int CW = $clog2(BINS + 1);
	localparam int RW = $clog2(2 * BINS);
	localparam int RCW = CENT_W + 1;
	localparam int PW = 2 * CENT_W + BW;
	localparam logic [BW-1:0] LAST_K = BW'(BINS - 1);
	localparam logic [RW-1:0] BINS_R = RW'(BINS);
	localparam longint unsigned RECIP = ((64'd1 << (CENT_W + BW)) + 64'(BINS - 1)) / 64'(BINS);
	localparam logic [RCW-1:0] RECIP_C = RCW'(RECIP);

	typedef enum logic [3:0] {
		ST_IDLE, ST_BIN, ST_ACC, ST_OUT, ST_UPD, ST_UPDW, ST_LEV, ST_RSTART, ST_RDIV, ST_RGEN
	} state_t;

	state_t state_q;
	logic [BW-1:0] k_q;
	logic [CW-1:0] cnt_q;
	logic signed [LEVEL_W-1:0] v_q;
	logic signed [SAMPLE_W-1:0] samp_q;
	logic last_q;
	logic [BW-1:0] bin_q;
	logic signed [CENT_W-1:0] rec_q;
	logic signed [SAMPLE_W-1:0] low_q;
	logic signed [SAMPLE_W-1:0] high_q;
	logic fresh_q;
	logic [CENT_W-1:0] qs_q;
	logic [RW-1:0] rs_q;
	logic [LEVEL_W-1:0] gq_q;
	logic [RW-1:0] gr_q;
	logic signed [LEVEL_W-1:0] prev_q;
	logic [PW-1:0] prod_q;
	logic result_valid_q;
	logic [CODE_W-1:0] bin_code_q;
	logic signed [CENT_W-1:0] recon_q;

	cell_t cur [BINS];
	cell_t nxt [BINS];
	cell_t head;
	cell_t tail_in;
	cell_ctl_t ctl;

	logic div_start;
	logic div_done;
	logic signed [DIVD_W-1:0] div_dividend;
	logic [CNT_W-1:0] div_divisor;
	logic signed [CENT_W-1:0] div_quo;

	logic signed [LEVEL_W-1:0] top_lv;
	logic signed [LEVEL_W-1:0] lo;
	logic [SAMPLE_W:0] diff;
	logic [CENT_W-1:0] span;
	logic [CENT_W-1:0] q_span;
	logic [CENT_W-1:0] r_span;
	logic [RW-1:0] r_sum;
	logic wrap;
	logic [RW-1:0] r_nx;
	logic [LEVEL_W-1:0] q_nx;
	logic signed [LEVEL_W-1:0] lev;
	logic signed [LEVEL_W:0] gen_sum;
	logic lt;
	logic [CW-1:0] cnt_nx;
	logic match;
	logic acc_en;
	logic out_load;

	assign head = cur[0];
	assign top_lv = {high_q[SAMPLE_W-1], high_q, 8'h01};
	assign lo = {low_q[SAMPLE_W-1], low_q, {FRAC_W{1'b0}}};
	assign diff = {high_q[SAMPLE_W-1], high_q} - {low_q[SAMPLE_W-1], low_q};
	assign span = {diff[SAMPLE_W-1:0], {FRAC_W{1'b0}}};
	assign q_span = prod_q[PW-1 -: CENT_W];
	assign r_span = span - q_span * CENT_W'(BINS);

	assign r_sum = gr_q + rs_q;
	assign wrap = r_sum >= BINS_R;
	assign r_nx = wrap ? r_sum - BINS_R : r_sum;
	assign q_nx = gq_q + {1'b0, qs_q} + LEVEL_W'(wrap);
	assign lev = lo + $signed(q_nx);
	assign gen_sum = {prev_q[LEVEL_W-1], prev_q} + {lev[LEVEL_W-1], lev};

	assign lt = head.level < v_q;
	assign cnt_nx = cnt_q + CW'(lt);
	assign match = k_q == bin_q;
	assign acc_en = match && (head.count < CNT_W'(COUNT_CAP));
	assign out_load = (state_q == ST_OUT) && (!result_valid_q || !result_stall);

	always_comb begin
		tail_in = head;
		case (state_q)
			ST_ACC: begin
				if (acc_en) begin
					tail_in.sum = head.sum + SUM_W'(samp_q);
					tail_in.count = head.count + 1'b1;
				end
			end
			ST_UPD, ST_UPDW: begin
				tail_in.centroid = (head.count == '0) ? head.centroid : div_quo;
				tail_in.sum = '0;
				tail_in.count = '0;
			end
			ST_RGEN: begin
				tail_in.level = (k_q == LAST_K) ? top_lv : lev;
				tail_in.centroid = gen_sum[CENT_W:1];
				tail_in.sum = '0;
				tail_in.count = '0;
			end
			default: begin
				tail_in = head;
			end
		endcase
	end

	always_comb begin
		ctl.shift = (state_q == ST_BIN) || (state_q == ST_ACC) || (state_q == ST_RGEN)
			|| ((state_q == ST_UPD) && (head.count == '0))
			|| ((state_q == ST_UPDW) && div_done);
		ctl.set_level = state_q == ST_LEV;
	end

	assign div_start = (state_q == ST_UPD) && (head.count != '0);
	assign div_dividend = $signed({head.sum, {FRAC_W{1'b0}}});
	assign div_divisor = head.count;

	genvar gi;
	generate
		for (gi = 0; gi < BINS; gi++) begin : g_cell
			if (gi == BINS - 1) begin : g_tail
				assign nxt[gi] = tail_in;
			end else begin : g_link
				assign nxt[gi] = cur[gi+1];
			end
			lmqt_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.ctl(ctl),
				.is_top(gi == BINS - 1),
				.top_level(top_lv),
				.nxt(nxt[gi]),
				.cur(cur[gi])
			);
		end
	endgenerate

	lmqt_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.done(div_done),
		.quotient(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
			cnt_q <= '0;
			low_q <= 16'sh7FFF;
			high_q <= -16'sh8000;
			fresh_q <= 1'b1;
			result_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						if (!kind) begin
							if (fresh_q) begin
								low_q <= sample;
								high_q <= sample;
								fresh_q <= 1'b0;
							end else begin
								if (sample < low_q) low_q <= sample;
								if (sample > high_q) high_q <= sample;
							end
							if (last_of_pass) state_q <= ST_RSTART;
						end else begin
							cnt_q <= '0;
							k_q <= '0;
							state_q <= ST_BIN;
						end
					end
				end
				ST_BIN: begin
					cnt_q <= cnt_nx;
					k_q <= k_q + 1'b1;
					if (k_q == LAST_K) begin
						k_q <= '0;
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					k_q <= k_q + 1'b1;
					if (k_q == LAST_K) begin
						k_q <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) state_q <= last_q ? ST_UPD : ST_IDLE;
				end
				ST_UPD: begin
					if (head.count == '0) begin
						k_q <= k_q + 1'b1;
						if (k_q == LAST_K) begin
							k_q <= '0;
							state_q <= ST_LEV;
						end
					end else begin
						state_q <= ST_UPDW;
					end
				end
				ST_UPDW: begin
					if (div_done) begin
						k_q <= k_q + 1'b1;
						state_q <= ST_UPD;
						if (k_q == LAST_K) begin
							k_q <= '0;
							state_q <= ST_LEV;
						end
					end
				end
				ST_LEV: begin
					fresh_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_RSTART: begin
					state_q <= ST_RDIV;
				end
				ST_RDIV: begin
					k_q <= '0;
					state_q <= ST_RGEN;
				end
				ST_RGEN: begin
					k_q <= k_q + 1'b1;
					if (k_q == LAST_K) begin
						k_q <= '0;
						fresh_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && item_valid) begin
			v_q <= {sample[SAMPLE_W-1], sample, {FRAC_W{1'b0}}};
			samp_q <= sample;
			last_q <= last_of_pass;
		end
		if ((state_q == ST_BIN) && (k_q == LAST_K)) begin
			bin_q <= (cnt_nx >= CW'(BINS)) ? LAST_K : BW'(cnt_nx);
		end
		if ((state_q == ST_ACC) && match) begin
			rec_q <= head.centroid;
		end
		if (out_load) begin
			bin_code_q <= CODE_W'(bin_q);
			recon_q <= rec_q;
		end
		if (state_q == ST_RSTART) begin
			prod_q <= PW'(span) * PW'(RECIP_C);
		end
		if (state_q == ST_RDIV) begin
			qs_q <= q_span;
			rs_q <= RW'(r_span);
			gq_q <= '0;
			gr_q <= '0;
			prev_q <= lo;
		end
		if (state_q == ST_RGEN) begin
			prev_q <= lev;
			gq_q <= q_nx;
			gr_q <= r_nx;
		end
	end

	assign item_stall = state_q != ST_IDLE;
	assign result_valid = result_valid_q;
	assign bin_code = bin_code_q;
	assign recon_value = recon_q;

	a_rise_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result raised outside output state");
	a_div_done_use: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_UPDW))
		else $error("divider finished with nobody waiting");
	a_idle_k_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (k_q == '0))
		else $error("chain left unaligned");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		head.count <= CNT_W'(COUNT_CAP))
		else $error("bin count above cap");
endmodule
